// File: rtl/pcmdm_pkg.sv
// ----------------------------------------------------------------------------
// pcmdm_pkg
// Shared types and constants for the PCM mono downmix block.
// ----------------------------------------------------------------------------
package pcmdm_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int OUT_BITS     = 24;

  localparam int IN_W       = 32;
  localparam int CNT_W      = 4;
  localparam int IDX_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SUM_W      = OUT_BITS + IDX_W;
  localparam int DIV_CNT_W  = $clog2(SUM_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH    = 3'd0,
    REG_FLOAT    = 3'd1,
    REG_SIGNED   = 3'd2,
    REG_ENDIAN   = 3'd3,
    REG_CHANNELS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]       width_code;
    logic             is_float;
    logic             is_signed;
    logic             big_endian;
    logic [CNT_W-1:0] channel_count;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_ACC,
    ST_DIV,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/pcmdm_norm.sv
// ----------------------------------------------------------------------------
// pcmdm_norm
// Decodes one raw sample (8/16/32-bit integer or 32-bit float, either byte
// order) into signed Q1.(OUT_BITS-1), saturating floats at -1.0 and just under +1.0.
// ----------------------------------------------------------------------------
module pcmdm_norm
  import pcmdm_pkg::*;
(
  input  cfg_t                       cfg,
  input  logic [IN_W-1:0]            raw,
  output logic signed [OUT_BITS-1:0] value
);

  localparam int INT_SHIFT = 32 - OUT_BITS;
  localparam logic [31:0] RND = 32'((64'd1 << INT_SHIFT) - 64'd1);

  logic [31:0]        w;
  logic [15:0]        h;
  logic [7:0]         s8;
  logic [15:0]        s16;
  logic [31:0]        i32;
  logic [31:0]        adj;
  logic               f_sign;
  logic [7:0]         f_exp;
  logic [22:0]        f_man;
  logic [23:0]        mant;
  logic [7:0]         e_eff;
  logic signed [9:0]  sh;
  logic [9:0]         rs;
  logic [31:0]        q;
  logic [OUT_BITS-1:0] f_val;

  assign w = cfg.big_endian ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
  assign h = cfg.big_endian ? {raw[7:0], raw[15:8]} : raw[15:0];

  assign s8  = cfg.is_signed ? raw[7:0] : {~raw[7], raw[6:0]};
  assign s16 = cfg.is_signed ? h : {~h[15], h[14:0]};
  assign i32 = cfg.is_signed ? w : {~w[31], w[30:0]};
  // bias negatives so the arithmetic shift truncates toward zero
  assign adj = i32 + (i32[31] ? RND : 32'd0);

  assign f_sign = w[31];
  assign f_exp  = w[30:23];
  assign f_man  = w[22:0];

  always_comb begin
    mant  = (f_exp == 8'd0) ? {1'b0, f_man} : {1'b1, f_man};
    e_eff = (f_exp == 8'd0) ? 8'd1 : f_exp;
    sh    = $signed({2'b00, e_eff}) - 10'sd150 + 10'(OUT_BITS - 1);
    rs    = 10'(-sh);
    if (sh >= 0) begin
      q = 32'(mant) << sh[4:0];
    end else if (rs >= 10'd32) begin
      q = 32'd0;
    end else begin
      q = 32'(mant) >> rs[4:0];
    end
    if (f_exp == 8'hFF && f_man != 23'd0) begin
      f_val = '0;
    end else if (f_exp >= 8'd127) begin
      f_val = f_sign ? {1'b1, {(OUT_BITS-1){1'b0}}} : {1'b0, {(OUT_BITS-1){1'b1}}};
    end else begin
      f_val = f_sign ? OUT_BITS'(-q) : q[OUT_BITS-1:0];
    end
  end

  always_comb begin
    case (cfg.width_code)
      WIDTH_8:  value = {s8, {(OUT_BITS-8){1'b0}}};
      WIDTH_16: value = {s16, {(OUT_BITS-16){1'b0}}};
      WIDTH_32: value = cfg.is_float ? f_val : adj[31:INT_SHIFT];
      default:  value = '0;
    endcase
  end

endmodule

// File: rtl/pcmdm_div.sv
// ----------------------------------------------------------------------------
// pcmdm_div
// Restoring divider, one quotient bit per cycle, unsigned dividend by a
// small channel count.
// ----------------------------------------------------------------------------
module pcmdm_div
  import pcmdm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CNT_W-1:0]     rem;
  logic [SUM_W-1:0]     quo;
  logic [CNT_W-1:0]     dvs;
  logic [CNT_W:0]       trial;
  logic                 ge;
  logic [CNT_W:0]       diff;

  assign trial = {rem, quo[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(SUM_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], ge};
      rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign rsp = '{done: done, quotient: quo};

endmodule

// File: rtl/pcm_sample_to_mono_downmix_core.sv
// ----------------------------------------------------------------------------
// pcm_sample_to_mono_downmix_core
// Takes one PCM sample per transaction, channels interleaved, normalizes it
// to signed Q1.23 and sums the frame. After the last channel of a frame the
// sum is divided by the channel count (truncating toward zero) and sent out
// as one mono sample. A sample that does not close a frame keeps in_ready low
// while it is normalized (ST_NORM) and added to the sum (ST_ACC), so no new
// sample is taken before the block is through with the last one. A sample
// that closes a frame goes through ST_NORM and ST_ACC, then ST_DIV in the
// restoring divider (one quotient bit per cycle over the 27-bit frame sum)
// and ST_SEND, which hands the result over once the output register is
// empty or its previous result is being taken. The finished mono sample
// sits in that output register, so the next frame starts while it waits.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only be changed while the block is idle.
// ----------------------------------------------------------------------------
module pcm_sample_to_mono_downmix_core
  import pcmdm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [IN_W-1:0]            sample_bytes,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] mono_sample
);

  localparam int CMP_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

  state_t                      state;
  state_t                      state_next;
  cfg_t                        cfg;
  logic [IN_W-1:0]             sample_reg;
  logic signed [OUT_BITS-1:0]  norm_out;
  logic signed [OUT_BITS-1:0]  norm_val;
  logic signed [SUM_W-1:0]     frame_sum;
  logic signed [SUM_W-1:0]     total;
  logic [IDX_W-1:0]            channel_index;
  logic [CNT_W-1:0]            cnt_eff;
  logic                        close_frame;
  logic                        neg;
  logic                        load_out;
  logic                        div_start;
  logic [OUT_BITS-1:0]         quo_low;
  div_req_t                    div_req;
  div_rsp_t                    div_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_code    <= WIDTH_16;
      cfg.is_float      <= 1'b0;
      cfg.is_signed     <= 1'b1;
      cfg.big_endian    <= 1'b0;
      cfg.channel_count <= CNT_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:    cfg.width_code    <= cfg_data[1:0];
        REG_FLOAT:    cfg.is_float      <= cfg_data[0];
        REG_SIGNED:   cfg.is_signed     <= cfg_data[0];
        REG_ENDIAN:   cfg.big_endian    <= cfg_data[0];
        REG_CHANNELS: cfg.channel_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one channel, large counts clamp to the supported maximum
  always_comb begin
    if (cfg.channel_count == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (CMP_W'(cfg.channel_count) > CMP_W'(MAX_CHANNELS)) begin
      cnt_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      cnt_eff = cfg.channel_count;
    end
  end

  pcmdm_norm u_norm (
    .cfg   (cfg),
    .raw   (sample_reg),
    .value (norm_out)
  );

  assign total = frame_sum + {{(SUM_W-OUT_BITS){norm_val[OUT_BITS-1]}}, norm_val};
  assign close_frame = !((CMP_W'(channel_index) + CMP_W'(1)) < CMP_W'(cnt_eff));

  assign div_req = '{start:    div_start,
                     dividend: total[SUM_W-1] ? SUM_W'(-total) : total,
                     divisor:  cnt_eff};

  pcmdm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: state_next = ST_ACC;
      ST_ACC: begin
        if (close_frame) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_reg <= sample_bytes;
    end
    if (state == ST_NORM) begin
      norm_val <= norm_out;
    end
    if (state == ST_ACC) begin
      neg <= total[SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_sum     <= '0;
      channel_index <= '0;
    end else if (state == ST_ACC) begin
      if (close_frame) begin
        frame_sum     <= '0;
        channel_index <= '0;
      end else begin
        frame_sum     <= total;
        channel_index <= channel_index + 1'b1;
      end
    end
  end

  assign quo_low = div_rsp.quotient[OUT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      mono_sample <= neg ? $signed(-quo_low) : $signed(quo_low);
    end
  end

endmodule

// File: rtl/pcmdm_chk.sv
// ----------------------------------------------------------------------------
// pcmdm_chk
// Port-level checks for the mono downmix core, bound to the top level.
// ----------------------------------------------------------------------------
module pcmdm_chk
  import pcmdm_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [OUT_BITS-1:0] mono_sample
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mono_sample))
    else $error("mono sample changed or dropped while stalled");

  // one sample in flight: ready drops right after a transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // no result can appear right behind an accepted sample
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after a sample");

  // reset empties the output and leaves the block ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind pcm_sample_to_mono_downmix_core pcmdm_chk u_pcmdm_chk (.*);

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PCM mono downmix core. A queue-fed driver sends
// raw sample words and a monitor checks every mono sample against an in-bench
// model of the format decoding, frame summing and averaging. Short directed
// phases come first, then randomized phases that sweep the register settings.
// ----------------------------------------------------------------------------
module tb
  import pcmdm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         SETTLE     = 48;     // covers the divider pass after a frame
  localparam int         IDLE_PCT   = 18;
  localparam int         RAND_ITEMS = 1550;
  localparam logic [1:0] WIDTH_NONE = 2'd3;   // unsupported sample width

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [IN_W-1:0]            sample_bytes = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [OUT_BITS-1:0] mono_sample;

  pcm_sample_to_mono_downmix_core u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_bytes(sample_bytes),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mono_sample (mono_sample)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // downmix model state and its copy of the registers
  logic [1:0]       width_cfg  = WIDTH_16;
  logic             float_cfg  = 1'b0;
  logic             signed_cfg = 1'b1;
  logic             endian_cfg = 1'b0;
  logic [CNT_W-1:0] chan_cfg   = 4'd2;
  int unsigned      chan_pos   = 0;
  longint           frame_acc  = 0;

  logic [IN_W-1:0]     sample_backlog[$];
  logic [OUT_BITS-1:0] mono_expected[$];
  int                  samples_queued = 0;
  int                  samples_taken  = 0;
  int                  monos_checked  = 0;
  int                  fail_count     = 0;
  int                  idle_pct       = IDLE_PCT;

  function automatic logic [31:0] byte_swap(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic longint float_to_q23(input logic [31:0] w);
    logic [7:0] e;
    longint     one;
    longint     mant;
    longint     q;
    int         sh;
    e   = w[30:23];
    one = longint'(1) << (OUT_BITS - 1);
    if (e == 8'hFF && w[22:0] != 0) return 0;
    if (e >= 8'd127) return w[31] ? -one : one - 1;
    if (e == 0) begin
      mant = longint'(w[22:0]);
      sh   = 1 - 150 + (OUT_BITS - 1);
    end else begin
      mant = longint'({1'b1, w[22:0]});
      sh   = int'(e) - 150 + (OUT_BITS - 1);
    end
    if (sh >= 0) q = mant << sh;
    else if (-sh >= 32) q = 0;
    else q = mant >> (-sh);
    return w[31] ? -q : q;
  endfunction

  function automatic longint decode_q23(input logic [31:0] b);
    logic [15:0] h;
    logic [31:0] w;
    longint      v;
    case (width_cfg)
      WIDTH_8: begin
        v = signed_cfg ? longint'($signed(b[7:0])) : longint'(b[7:0]) - 128;
        return v * (longint'(1) << (OUT_BITS - 8));
      end
      WIDTH_16: begin
        h = endian_cfg ? {b[7:0], b[15:8]} : b[15:0];
        v = signed_cfg ? longint'($signed(h)) : longint'(h) - 32768;
        return v * (longint'(1) << (OUT_BITS - 16));
      end
      WIDTH_32: begin
        w = endian_cfg ? byte_swap(b) : b;
        if (float_cfg) return float_to_q23(w);
        v = signed_cfg ? longint'($signed(w)) : longint'(w) - 64'sd2147483648;
        return v / (longint'(1) << (32 - OUT_BITS));
      end
      default: return 0;
    endcase
  endfunction

  // adds one channel to the frame; returns 1 when the frame closes
  function automatic bit fold_sample(input logic [31:0] b, output logic [OUT_BITS-1:0] mono);
    int unsigned cnt;
    longint      avg;
    cnt = 32'(chan_cfg);
    if (cnt == 0) cnt = 1;
    if (cnt > MAX_CHANNELS) cnt = MAX_CHANNELS;
    frame_acc += decode_q23(b);
    mono = '0;
    if (chan_pos + 1 < cnt) begin
      chan_pos++;
      return 1'b0;
    end
    avg       = frame_acc / longint'(cnt);
    mono      = avg[OUT_BITS-1:0];
    chan_pos  = 0;
    frame_acc = 0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : feed_proc
    bit                  hold_off;
    logic [OUT_BITS-1:0] mono;
    hold_off = ($urandom_range(99) < idle_pct);
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        samples_taken++;
        if (fold_sample(sample_bytes, mono))
          mono_expected.insert(mono_expected.size(), mono);
      end
      if (!in_valid || in_ready) begin
        if (sample_backlog.size() != 0 && !hold_off) begin
          in_valid     <= 1'b1;
          sample_bytes <= sample_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : sink_proc
    logic [OUT_BITS-1:0] want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (mono_expected.size() == 0) begin
          $error("mono_sample: unexpected transaction, actual %0d", mono_sample);
          fail_count++;
        end else begin
          want = mono_expected.pop_front();
          monos_checked++;
          if (mono_sample !== want) begin
            $error("mono_sample mismatch: expected %0d, actual %0d", $signed(want), mono_sample);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_WIDTH:    width_cfg  = val[1:0];
      REG_FLOAT:    float_cfg  = val[0];
      REG_SIGNED:   signed_cfg = val[0];
      REG_ENDIAN:   endian_cfg = val[0];
      REG_CHANNELS: chan_cfg   = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // upper data bits are random so the register masking gets exercised
  task automatic configure(input logic [1:0] wsel, input logic fl, input logic sg,
                           input logic be, input logic [CNT_W-1:0] chans);
    write_reg(REG_WIDTH, {2'($urandom), wsel});
    write_reg(REG_FLOAT, {3'($urandom), fl});
    write_reg(REG_SIGNED, {3'($urandom), sg});
    write_reg(REG_ENDIAN, {3'($urandom), be});
    write_reg(REG_CHANNELS, chans);
    end_writes();
  endtask

  task automatic push(input logic [IN_W-1:0] b);
    sample_backlog.insert(sample_backlog.size(), b);
    samples_queued++;
  endtask

  // wait for every queued sample and every mono sample, then let the core go idle
  task automatic settle();
    do @(posedge clk);
    while (samples_taken != samples_queued || mono_expected.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stim_proc
    int           phases;
    int           rand_sent;
    int           n;
    logic [1:0]   wsel;
    logic [3:0]   chans;
    logic [31:0]  b;
    logic [3:0]   chan_pick[4];
    logic [31:0]  edge_words[8];
    chan_pick  = '{4'd0, 4'd1, 4'd8, 4'd15};
    edge_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h0000_0080, 32'hFFFF_FF7F, 32'h8080_8080, 32'h7F7F_7F7F};
    phases    = 0;
    rand_sent = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // reset settings: 16-bit signed little endian, stereo
    push(32'h1234_8000);
    push(32'hABCD_7FFF);
    push(32'h0000_FFFF);
    push(32'hFFFF_0001);
    settle();

    // 8-bit offset binary; float and byte order must be ignored at this width
    configure(WIDTH_8, 1'b1, 1'b0, 1'b1, 4'd1);
    push(32'hFFFF_FF00);
    push(32'h0000_00FF);
    push(32'h0000_0080);
    push(32'h0000_007F);
    settle();

    // float: +/-1, NaN, +/-inf, denormal, and in-range values
    configure(WIDTH_32, 1'b1, 1'b1, 1'b0, 4'd1);
    push(32'h3F80_0000);
    push(32'hBF80_0000);
    push(32'h7FC0_0000);
    push(32'h7F80_0000);
    push(32'hFF80_0000);
    push(32'h0000_0001);
    push(32'h3F00_0000);
    push(32'hBF40_0000);
    push(32'h3F7F_FFFF);
    settle();

    // 32-bit offset binary, big endian
    configure(WIDTH_32, 1'b0, 1'b0, 1'b1, 4'd1);
    push(32'h0000_0080);
    push(32'hFFFF_FFFF);
    settle();

    // channel count lowered in the middle of a frame
    configure(WIDTH_16, 1'b0, 1'b1, 1'b0, 4'd4);
    push(32'h0000_7FFF);
    push(32'h0000_7FFF);
    push(32'h0000_8001);
    settle();
    write_reg(REG_CHANNELS, 4'd2);
    for (int r = int'(REG_CHANNELS) + 1; r < (1 << CFG_IDX_W); r++)
      write_reg(CFG_IDX_W'(r), 4'($urandom));
    end_writes();
    push(32'h0000_7FFF);
    settle();

    // unsupported width still occupies its channel slot
    configure(WIDTH_NONE, 1'b0, 1'b1, 1'b0, 4'd1);
    push(32'hDEAD_BEEF);
    settle();

    while (rand_sent < RAND_ITEMS) begin
      idle_pct = (phases >= 10 && phases < 14) ? 0 : IDLE_PCT;
      case ($urandom_range(9))
        0, 1, 2: wsel = WIDTH_8;
        3, 4, 5: wsel = WIDTH_16;
        6, 7, 8: wsel = WIDTH_32;
        default: wsel = WIDTH_NONE;
      endcase
      if (phases < 4) chans = chan_pick[phases];
      else if ($urandom_range(3) != 0) chans = 4'($urandom_range(1, MAX_CHANNELS));
      else chans = 4'($urandom);
      configure(wsel, 1'($urandom), 1'($urandom), 1'($urandom), chans);
      n = $urandom_range(40, 90);
      repeat (n) begin
        case ($urandom_range(7))
          0: b = edge_words[$urandom_range(7)];
          1, 2: begin
            // floats near full scale; swapped into stored order for big endian
            b = {1'($urandom), 8'($urandom_range(110, 128)), 23'($urandom)};
            if (endian_cfg) b = byte_swap(b);
          end
          3: begin
            b = {1'($urandom), ($urandom_range(1) != 0) ? 8'hFF : 8'h00,
                 ($urandom_range(1) != 0) ? 23'($urandom) : 23'd0};
            if (endian_cfg) b = byte_swap(b);
          end
          default: b = $urandom;
        endcase
        push(b);
      end
      rand_sent += n;
      settle();
      phases++;
    end

    idle_pct = IDLE_PCT;
    $display("tb: %0d samples in %0d random phases plus directed cases, %0d mono samples checked",
             samples_taken, phases, monos_checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
